[design/vnce_pkg.sv]
// Package for the vertex normal colour encoder: types, codes and constants.
package vnce_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COORD_WIDTH_DEF  = 16;
  localparam int SUM_W            = 22;
  localparam int IDX_W            = 10;
  localparam int VTX_W            = 48;

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_EMIT  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [0:0] CFG_SMOOTH = 1'b0;
  localparam logic [0:0] CFG_ALPHA  = 1'b1;

  typedef struct packed {
    logic [1:0]       operation;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
    logic [VTX_W-1:0] vertex_c;
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
    logic [IDX_W-1:0] index_c;
  } req_t;

  typedef struct packed {
    logic [1:0] corner;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CROSS,
    ST_NORM,
    ST_ACC_RD,
    ST_ACC_WAIT,
    ST_ACC_WR,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT_NORM,
    ST_EMIT_OUT
  } state_t;

  // Byte encoding of one Q2.15 component.
  function automatic logic [7:0] encode(input logic signed [16:0] v);
    logic [16:0] u;
    logic [24:0] p;
    begin
      u = v + 17'sd32768;
      p = {8'd0, u} * 25'd255;
      encode = p[23:16];
    end
  endfunction

endpackage

[design/vnce_norm.sv]
// Sequential normalizer: scale to bit 30, integer square root, per-component divide.
module vnce_norm (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [63:0]  cx,
  input  logic signed [63:0]  cy,
  input  logic signed [63:0]  cz,
  output logic                done,
  output logic signed [16:0]  nx,
  output logic signed [16:0]  ny,
  output logic signed [16:0]  nz
);

  typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DIV, N_DONE} nst_t;

  nst_t        st;
  logic [62:0] m [3];
  logic [2:0]  neg;
  logic [63:0] l2;
  logic [35:0] rem;
  logic [31:0] root;
  logic [4:0]  step;
  logic [1:0]  comp;
  logic [33:0] drem;
  logic [15:0] q;
  logic [3:0]  dcnt;
  logic [16:0] res [3];

  logic [62:0] mx;
  logic [5:0]  lead;
  logic [61:0] sq;
  logic [35:0] rem_t;
  logic [36:0] trial;
  logic [34:0] dsub;
  logic        qbit;
  logic [15:0] q_new;

  always_comb begin
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    lead = 6'd0;
    for (int i = 0; i < 63; i++) begin
      if (mx[i]) lead = 6'(i);
    end
    sq    = m[comp][30:0] * m[comp][30:0];
    rem_t = {rem[33:0], l2[63:62]};
    trial = {1'b0, rem_t} - {3'b000, root, 2'b01};
    // The scaled component never exceeds the length, so 16 quotient bits suffice.
    dsub  = {1'b0, drem} - {3'b000, root};
    qbit  = !dsub[34];
    q_new = {q[14:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= N_IDLE;
      done <= 1'b0;
    end else begin
      done <= (st == N_DONE);
      case (st)
        N_IDLE: if (start && !done) begin
          neg  <= {cz[63], cy[63], cx[63]};
          m[0] <= cx[63] ? 63'(-cx) : 63'(cx);
          m[1] <= cy[63] ? 63'(-cy) : 63'(cy);
          m[2] <= cz[63] ? 63'(-cz) : 63'(cz);
          st   <= N_SHIFT;
        end
        N_SHIFT: begin
          if (mx == 63'd0) begin
            res[0] <= 17'd0; res[1] <= 17'd0; res[2] <= 17'd0;
            st <= N_DONE;
          end else begin
            for (int i = 0; i < 3; i++) begin
              if (lead > 6'd30) m[i] <= m[i] >> (lead - 6'd30);
              else m[i] <= m[i] << (6'd30 - lead);
            end
            comp <= 2'd0;
            l2   <= 64'd0;
            st   <= N_SQ;
          end
        end
        N_SQ: begin
          l2 <= l2 + {2'b00, sq};
          if (comp == 2'd2) begin
            st <= N_SQRT; step <= 5'd0; rem <= 36'd0; root <= 32'd0;
          end else comp <= comp + 2'd1;
        end
        N_SQRT: begin
          // One result bit per cycle, restoring square root.
          if (!trial[36]) begin
            rem  <= trial[35:0];
            root <= {root[30:0], 1'b1};
          end else begin
            rem  <= rem_t;
            root <= {root[30:0], 1'b0};
          end
          l2   <= {l2[61:0], 2'b00};
          step <= step + 5'd1;
          if (step == 5'd31) begin
            st <= N_DIV; comp <= 2'd0;
            drem <= {3'b000, m[0][30:0]}; q <= 16'd0; dcnt <= 4'd0;
          end
        end
        N_DIV: begin
          if (dcnt == 4'd15) begin
            if (neg[comp]) res[comp] <= -{1'b0, q_new};
            else res[comp] <= (q_new > 16'd32767) ? 17'd32767 : {1'b0, q_new};
            if (comp == 2'd2) st <= N_DONE;
            else begin
              comp <= comp + 2'd1;
              drem <= {3'b000, m[comp + 2'd1][30:0]};
              q    <= 16'd0;
              dcnt <= 4'd0;
            end
          end else begin
            drem <= qbit ? {dsub[32:0], 1'b0} : {drem[32:0], 1'b0};
            q    <= q_new;
            dcnt <= dcnt + 4'd1;
          end
        end
        N_DONE: st <= N_IDLE;
        default: st <= N_IDLE;
      endcase
    end
  end

  assign nx = res[0];
  assign ny = res[1];
  assign nz = res[2];

endmodule

[design/vertex_normal_colour_encoder_unit.sv]
// Top level of the vertex normal colour encoder.
// One request at a time, set by the shared normalizer: 32 square-root steps, then 16 divide
// steps per component. A smooth emit normalizes each corner's sum; a flat emit, the face
// once. A zero-length vector skips the square root and the divides. Each result is strobed
// in the cycle after its output state and the receiver cannot stall. After reset, and for a
// clear request, a clearing pass zeroes all MAX_VERTICES entries with busy high.
module vertex_normal_colour_encoder_unit #(
  parameter int MAX_VERTICES = vnce_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = vnce_pkg::COORD_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  vnce_pkg::req_t  request,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_data,
  output logic            result_valid,
  output vnce_pkg::res_t  result
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int SW = vnce_pkg::SUM_W;
  localparam int EW = COORD_WIDTH + 1;

  vnce_pkg::state_t st, st_next;
  vnce_pkg::req_t   rq;
  logic             smooth;
  logic [7:0]       alpha_reg;
  logic [AW:0]      clr_cnt;
  logic [1:0]       k;

  logic [3*SW-1:0]  mem [MAX_VERTICES];
  logic [3*SW-1:0]  rd_data;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic             wr_en;
  logic [3*SW-1:0]  wr_data;

  logic             n_start, n_done;
  logic signed [63:0] c_x, c_y, c_z;
  logic signed [16:0] n_x, n_y, n_z;
  logic signed [16:0] fn [3];
  logic signed [63:0] crs [3];
  logic [9:0]       cur_idx;
  logic             idx_ok;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  function automatic logic signed [COORD_WIDTH-1:0] crd(input logic [vnce_pkg::VTX_W-1:0] v,
                                                         input int c);
    begin
      crd = COORD_WIDTH'(v >> (c * COORD_WIDTH));
    end
  endfunction

  function automatic logic [SW-1:0] sat(input logic [SW-1:0] s, input logic signed [16:0] v);
    logic signed [SW:0] r;
    begin
      r = (SW+1)'(signed'(s)) + (SW+1)'(v);
      if (r[SW] != r[SW-1]) sat = r[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      else sat = r[SW-1:0];
    end
  endfunction

  always_comb begin
    unique case (k)
      2'd0: cur_idx = rq.index_a;
      2'd1: cur_idx = rq.index_b;
      default: cur_idx = rq.index_c;
    endcase
    idx_ok  = 32'(cur_idx) < MAX_VERTICES;
    rd_addr = AW'(cur_idx);
  end

  // Cross product of the edges b-a and c-a, registered before normalizing.
  always_ff @(posedge clk) begin
    if (st == vnce_pkg::ST_CROSS) begin
      logic signed [EW-1:0] e0 [3], e1 [3];
      logic signed [2*EW:0] p [3];
      for (int i = 0; i < 3; i++) begin
        e0[i] = EW'(crd(rq.vertex_b, i)) - EW'(crd(rq.vertex_a, i));
        e1[i] = EW'(crd(rq.vertex_c, i)) - EW'(crd(rq.vertex_a, i));
      end
      p[0] = e0[1] * e1[2] - e0[2] * e1[1];
      p[1] = e0[2] * e1[0] - e0[0] * e1[2];
      p[2] = e0[0] * e1[1] - e0[1] * e1[0];
      for (int i = 0; i < 3; i++) crs[i] <= 64'(p[i]);
    end
  end

  always_comb begin
    if (st == vnce_pkg::ST_EMIT_WAIT) begin
      c_x = idx_ok ? 64'(signed'(rd_data[SW-1:0]))      : 64'd0;
      c_y = idx_ok ? 64'(signed'(rd_data[2*SW-1:SW]))   : 64'd0;
      c_z = idx_ok ? 64'(signed'(rd_data[3*SW-1:2*SW])) : 64'd0;
    end else begin
      c_x = crs[0]; c_y = crs[1]; c_z = crs[2];
    end
  end

  assign n_start = (st == vnce_pkg::ST_NORM) || (st == vnce_pkg::ST_EMIT_WAIT);

  vnce_norm u_norm (
    .clk(clk), .rst(rst), .start(n_start),
    .cx(c_x), .cy(c_y), .cz(c_z),
    .done(n_done), .nx(n_x), .ny(n_y), .nz(n_z)
  );

  always_comb begin
    st_next = st;
    unique case (st)
      vnce_pkg::ST_IDLE: if (start) begin
        unique case (vnce_pkg::op_t'(request.operation))
          vnce_pkg::OP_CLEAR: st_next = vnce_pkg::ST_CLEAR;
          vnce_pkg::OP_ACCUM: st_next = vnce_pkg::ST_CROSS;
          vnce_pkg::OP_EMIT:  st_next = smooth ? vnce_pkg::ST_EMIT_RD : vnce_pkg::ST_CROSS;
          default:            st_next = vnce_pkg::ST_IDLE;
        endcase
      end
      vnce_pkg::ST_CLEAR: if (clr_cnt == (AW+1)'(MAX_VERTICES - 1)) st_next = vnce_pkg::ST_IDLE;
      vnce_pkg::ST_CROSS: st_next = vnce_pkg::ST_NORM;
      vnce_pkg::ST_NORM: if (n_done) st_next =
        (rq.operation == vnce_pkg::OP_ACCUM) ? vnce_pkg::ST_ACC_RD : vnce_pkg::ST_EMIT_OUT;
      vnce_pkg::ST_ACC_RD:   st_next = vnce_pkg::ST_ACC_WAIT;
      vnce_pkg::ST_ACC_WAIT: st_next = vnce_pkg::ST_ACC_WR;
      vnce_pkg::ST_ACC_WR: st_next = (k == 2'd2) ? vnce_pkg::ST_IDLE : vnce_pkg::ST_ACC_RD;
      vnce_pkg::ST_EMIT_RD:   st_next = vnce_pkg::ST_EMIT_WAIT;
      vnce_pkg::ST_EMIT_WAIT: st_next = vnce_pkg::ST_EMIT_NORM;
      vnce_pkg::ST_EMIT_NORM: if (n_done) st_next = vnce_pkg::ST_EMIT_OUT;
      vnce_pkg::ST_EMIT_OUT: begin
        if (k == 2'd2) st_next = vnce_pkg::ST_IDLE;
        else if (smooth) st_next = vnce_pkg::ST_EMIT_RD;
      end
      default: st_next = vnce_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = (st != vnce_pkg::ST_IDLE);
    wr_en   = 1'b0;
    wr_addr = rd_addr;
    wr_data = {sat(rd_data[3*SW-1:2*SW], fn[2]), sat(rd_data[2*SW-1:SW], fn[1]),
               sat(rd_data[SW-1:0], fn[0])};
    if (st == vnce_pkg::ST_CLEAR) begin
      wr_en = 1'b1; wr_addr = clr_cnt[AW-1:0]; wr_data = '0;
    end else if (st == vnce_pkg::ST_ACC_WR) begin
      wr_en = idx_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= vnce_pkg::ST_CLEAR;
      clr_cnt <= '0;
      k <= 2'd0;
      smooth <= 1'b0;
      alpha_reg <= 8'd0;
      result_valid <= 1'b0;
    end else begin
      st <= st_next;
      result_valid <= (st == vnce_pkg::ST_EMIT_OUT);
      if (cfg_we) begin
        if (cfg_index == vnce_pkg::CFG_SMOOTH) smooth <= cfg_data[0];
        else alpha_reg <= cfg_data;
      end
      if (st == vnce_pkg::ST_IDLE) begin
        k <= 2'd0; clr_cnt <= '0;
        if (start) rq <= request;
      end
      if (st == vnce_pkg::ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (n_done) begin
        fn[0] <= n_x; fn[1] <= n_y; fn[2] <= n_z;
      end
      if (st == vnce_pkg::ST_ACC_WR) k <= k + 2'd1;
      if (st == vnce_pkg::ST_EMIT_OUT) begin
        result.corner <= k;
        result.blue   <= vnce_pkg::encode(fn[2]);
        result.green  <= vnce_pkg::encode(fn[1]);
        result.red    <= vnce_pkg::encode(fn[0]);
        result.alpha  <= alpha_reg;
        result.last   <= (k == 2'd2);
        k <= k + 2'd1;
      end
    end
  end

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy || $past(st == vnce_pkg::ST_EMIT_OUT)) else $error("strobe out of emit");
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> result.corner == 2'd2) else $error("last on wrong corner");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> busy) else $error("store write while idle");

endmodule

[dv/vnce_scoreboard.sv]
// Checker for the vertex normal colour encoder: predicts every colour and compares it.
`timescale 1ns / 1ps
module vnce_scoreboard (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  vnce_pkg::req_t  request,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_data,
  input  logic            result_valid,
  input  vnce_pkg::res_t  result,
  output int              fail_count,
  output int              colours_pending,
  output int              colours_seen
);
  import vnce_pkg::*;

  localparam int SUM_HI = 2097151;
  localparam int SUM_LO = -2097152;

  int     acc_x [MAX_VERTICES_DEF];
  int     acc_y [MAX_VERTICES_DEF];
  int     acc_z [MAX_VERTICES_DEF];
  logic   smooth_q;
  logic [7:0] alpha_q;
  res_t   colour_q [$];

  assign colours_pending = colour_q.size();

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scale so the largest magnitude has its top bit at 30, then divide by the length.
  function automatic void unit_vec(input longint cx, input longint cy, input longint cz,
                                   output int nx, output int ny, output int nz);
    longint c [3];
    longint unsigned m [3];
    longint unsigned mx, l2, len, q;
    int n [3];
    int p;
    c[0] = cx; c[1] = cy; c[2] = cz;
    mx = 0;
    l2 = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (c[i] < 0) ? longint'(-c[i]) : c[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      nx = 0; ny = 0; nz = 0;
      return;
    end
    p = 0;
    while ((mx >> p) > 1) p++;
    for (int i = 0; i < 3; i++) begin
      if (p > 30) m[i] = m[i] >> (p - 30);
      else m[i] = m[i] << (30 - p);
      l2 += m[i] * m[i];
    end
    len = int_sqrt(l2);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 32768) / len;
      if (c[i] < 0) n[i] = -int'((q > 32768) ? 32768 : q);
      else n[i] = int'((q > 32767) ? 32767 : q);
    end
    nx = n[0]; ny = n[1]; nz = n[2];
  endfunction

  function automatic longint coord(input logic [VTX_W-1:0] v, input int k);
    return longint'($signed(v[k*16 +: 16]));
  endfunction

  function automatic void face_dir(input req_t r, output int nx, output int ny,
                                   output int nz);
    longint e0 [3];
    longint e1 [3];
    for (int k = 0; k < 3; k++) begin
      e0[k] = coord(r.vertex_b, k) - coord(r.vertex_a, k);
      e1[k] = coord(r.vertex_c, k) - coord(r.vertex_a, k);
    end
    unit_vec(e0[1] * e1[2] - e0[2] * e1[1], e0[2] * e1[0] - e0[0] * e1[2],
             e0[0] * e1[1] - e0[1] * e1[0], nx, ny, nz);
  endfunction

  function automatic int clamp_sum(input int s, input int v);
    longint t;
    t = longint'(s) + v;
    if (t > SUM_HI) t = SUM_HI;
    if (t < SUM_LO) t = SUM_LO;
    return int'(t);
  endfunction

  function automatic logic [7:0] to_byte(input int v);
    longint t;
    t = ((longint'(v) + 32768) * 255) >> 16;
    return t[7:0];
  endfunction

  task automatic apply_request(input req_t r);
    int nx, ny, nz, vx, vy, vz;
    logic [IDX_W-1:0] idx [3];
    res_t c;
    idx[0] = r.index_a; idx[1] = r.index_b; idx[2] = r.index_c;
    case (op_t'(r.operation))
      OP_CLEAR: begin
        for (int i = 0; i < MAX_VERTICES_DEF; i++) begin
          acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
        end
      end
      OP_ACCUM: begin
        face_dir(r, nx, ny, nz);
        for (int k = 0; k < 3; k++) begin
          acc_x[idx[k]] = clamp_sum(acc_x[idx[k]], nx);
          acc_y[idx[k]] = clamp_sum(acc_y[idx[k]], ny);
          acc_z[idx[k]] = clamp_sum(acc_z[idx[k]], nz);
        end
      end
      OP_EMIT: begin
        face_dir(r, nx, ny, nz);
        for (int k = 0; k < 3; k++) begin
          if (smooth_q) unit_vec(acc_x[idx[k]], acc_y[idx[k]], acc_z[idx[k]], vx, vy, vz);
          else begin
            vx = nx; vy = ny; vz = nz;
          end
          c.corner = k[1:0];
          c.blue   = to_byte(vz);
          c.green  = to_byte(vy);
          c.red    = to_byte(vx);
          c.alpha  = alpha_q;
          c.last   = (k == 2);
          colour_q.push_back(c);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      for (int i = 0; i < MAX_VERTICES_DEF; i++) begin
        acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
      end
      smooth_q = 1'b0;
      alpha_q  = 8'd0;
      colour_q.delete();
      fail_count   <= 0;
      colours_seen <= 0;
    end else begin
      // The last colour may leave in the same cycle that the next request is taken.
      if (result_valid) begin
        colours_seen <= colours_seen + 1;
        if (colour_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected colour %p", result);
          fail_count <= fail_count + 1;
        end else begin
          want = colour_q.pop_front();
          if (want !== result) begin
            if (fail_count < 10) $display("colour mismatch: expected %p got %p", want, result);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_SMOOTH) smooth_q = cfg_data[0];
        else alpha_q = cfg_data;
      end
      if (start && !busy) apply_request(request);
    end
  end
endmodule

[dv/vertex_normal_colour_encoder_unit_test.sv]
// Stimulus and verdict for the vertex normal colour encoder.
`timescale 1ns / 1ps
module vertex_normal_colour_encoder_unit_test;
  import vnce_pkg::*;

  logic clk, rst, start, busy, cfg_we, cfg_index, result_valid;
  logic [7:0] cfg_data;
  req_t request;
  res_t result;
  int   fail_count, colours_pending, colours_seen;
  int   requests_sent;
  bit   quiet;

  vertex_normal_colour_encoder_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .result(result)
  );

  vnce_scoreboard checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .result(result), .fail_count(fail_count),
    .colours_pending(colours_pending), .colours_seen(colours_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [VTX_W-1:0] pack(input int x, input int y, input int z);
    logic [15:0] px, py, pz;
    px = x[15:0]; py = y[15:0]; pz = z[15:0];
    return {pz, py, px};
  endfunction

  function automatic logic [VTX_W-1:0] rand_vertex();
    logic [63:0] w;
    w = {$urandom, $urandom};
    // Small coordinates give realistic meshes; full range covers every bit.
    if ($urandom_range(0, 2) == 0) return w[VTX_W-1:0];
    return pack($urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
                $urandom_range(0, 600) - 300);
  endfunction

  function automatic req_t tri_req(input op_t op, input logic [VTX_W-1:0] a,
                                   input logic [VTX_W-1:0] b, input logic [VTX_W-1:0] c,
                                   input int ia, input int ib, input int ic);
    req_t r;
    r.operation = op;
    r.vertex_a = a; r.vertex_b = b; r.vertex_c = c;
    r.index_a = ia[IDX_W-1:0]; r.index_b = ib[IDX_W-1:0]; r.index_c = ic[IDX_W-1:0];
    return r;
  endfunction

  // Leaves the request on the port; it is taken at the next rising edge.
  task automatic send(input req_t r);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      @(posedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 12)) @(posedge clk);
    end
    @(posedge clk);
    start   <= 1'b1;
    request <= r;
    requests_sent++;
    @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic wait_colours();
    @(posedge clk);
    start <= 1'b0;
    @(negedge clk);
    while (colours_pending != 0) @(negedge clk);
  endtask

  // Accumulate and clear produce no colours, so allow their full latency to pass.
  task automatic write_reg(input logic idx, input logic [7:0] val);
    wait_colours();
    repeat (200) @(posedge clk);
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input bit smooth, input int count);
    int base, pick, sent_here;
    sent_here = 0;
    base = $urandom_range(0, 1015);
    while (sent_here < count) begin
      if (requests_sent > 330) quiet = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // Noise: any operation code, any indices.
        send(tri_req(op_t'($urandom_range(0, 3)), rand_vertex(), rand_vertex(),
                     rand_vertex(), $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 1023)));
        sent_here++;
      end else if (pick == 1) begin
        // Hammer one vertex with an axis normal to drive its sum into saturation.
        int sgn;
        sgn = $urandom_range(0, 1) ? 100 : -100;
        repeat (24) send(tri_req(OP_ACCUM, pack(0, 0, 0), pack(sgn, 0, 0), pack(0, 100, 0),
                                 base, base, base));
        send(tri_req(OP_EMIT, rand_vertex(), rand_vertex(), rand_vertex(),
                     base, base + 1, base + 8));
        send(tri_req(OP_CLEAR, rand_vertex(), rand_vertex(), rand_vertex(), 0, 0, 0));
        sent_here += 26;
        base = $urandom_range(0, 1015);
      end else if (smooth) begin
        repeat ($urandom_range(2, 6)) begin
          send(tri_req(OP_ACCUM, rand_vertex(), rand_vertex(), rand_vertex(),
                       base + $urandom_range(0, 7), base + $urandom_range(0, 7),
                       base + $urandom_range(0, 7)));
          sent_here++;
        end
        repeat ($urandom_range(1, 3)) begin
          send(tri_req(OP_EMIT, rand_vertex(), rand_vertex(), rand_vertex(),
                       base + $urandom_range(0, 7), base + $urandom_range(0, 7),
                       base + $urandom_range(0, 7)));
          sent_here++;
        end
      end else begin
        send(tri_req(OP_EMIT, rand_vertex(), rand_vertex(), rand_vertex(),
                     $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 1023)));
        sent_here++;
      end
    end
  endtask

  initial begin
    logic [VTX_W-1:0] ones;
    ones = '1;
    rst = 1'b1; start = 1'b0; cfg_we = 1'b0; cfg_index = CFG_SMOOTH; cfg_data = 8'd0;
    request = '0; requests_sent = 0; quiet = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // The store is cleared after reset with busy high.
    @(negedge clk);
    while (busy) @(negedge clk);

    // Flat mode at reset settings: signs, degenerate and extreme triangles, then no-op, accumulate and clear.
    send(tri_req(OP_EMIT, pack(0, 0, 0), pack(256, 0, 0), pack(0, 256, 0), 0, 1, 2));
    send(tri_req(OP_EMIT, pack(0, 0, 0), pack(0, 256, 0), pack(256, 0, 0), 0, 1, 2));
    send(tri_req(OP_EMIT, pack(5, 5, 5), pack(5, 5, 5), pack(5, 5, 5), 0, 1, 2));
    send(tri_req(OP_EMIT, pack(-32768, -32768, -32768), pack(32767, -32768, 32767),
                 pack(-32768, 32767, 32767), 1023, 1023, 1023));
    send(tri_req(OP_EMIT, ones, '0, ones, 0, 0, 0));
    send(tri_req(OP_EMIT, '0, pack(32767, 0, 0), pack(0, 0, 32767), 0, 0, 0));
    send(tri_req(OP_NONE, ones, ones, ones, 1023, 1023, 1023));
    send(tri_req(OP_ACCUM, pack(0, 0, 0), pack(0, 0, 256), pack(256, 0, 0), 0, 1023, 0));
    send(tri_req(OP_CLEAR, '0, '0, '0, 0, 0, 0));
    send(tri_req(OP_ACCUM, pack(0, 0, 0), pack(256, 0, 0), pack(0, 256, 0), 0, 1023, 9));

    write_reg(CFG_SMOOTH, 8'd1);
    write_reg(CFG_ALPHA, 8'd255);
    send(tri_req(OP_EMIT, ones, ones, ones, 0, 1023, 7));
    // Repeated index in one triangle adds its normal three times to the same sum.
    repeat (12) send(tri_req(OP_ACCUM, pack(0, 0, 0), pack(100, 0, 0), pack(0, 100, 0),
                             5, 5, 5));
    send(tri_req(OP_EMIT, '0, '0, '0, 5, 9, 6));

    wait_colours();
    random_phase(1'b1, 90);
    write_reg(CFG_ALPHA, 8'($urandom_range(1, 254)));
    random_phase(1'b1, 80);
    write_reg(CFG_SMOOTH, 8'd0);
    random_phase(1'b0, 80);
    write_reg(CFG_ALPHA, 8'd0);
    write_reg(CFG_SMOOTH, 8'd1);
    random_phase(1'b1, 90);

    wait_colours();
    repeat (200) @(posedge clk);
    $display("Sent %0d requests over flat and smooth phases; %0d colours compared.",
             requests_sent, colours_seen);
    if (fail_count == 0 && colours_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
